/* hw/rtl/clle_pkg.sv */
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and codes of the cursor linked-list engine: request codes,
// classified commands and the states of the execution sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clle_pkg;

  localparam int unsigned NODE_COUNT_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_LOCATE = 2'd3;

  typedef enum logic [2:0] {
    OP_REJECT,
    OP_CREATE,
    OP_INSERT,
    OP_DELETE,
    OP_LOCATE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  head;
    logic [7:0]  rem;
    logic [31:0] val;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_CR_HEAD,
    ST_CR_POP,
    ST_CR_END,
    ST_INS_HEAD,
    ST_INS_POP,
    ST_INS_FILL,
    ST_INS_HOOK,
    ST_DEL_GET,
    ST_DEL_UNLINK,
    ST_DEL_VAL,
    ST_DEL_FREE,
    ST_DEL_END,
    ST_LOC_FIRST,
    ST_LOC,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/cursor_linked_list_engine_top.sv */
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top
// Static linked lists in a fixed node store that also holds the free chain:
// create, insert, delete and locate requests, one result per request.
// ----------------------------------------------------------------------------
//  port group  direction  handshake           payload
//  in_*        input      in_valid/in_stall   req_type, list_head, position,
//                                             item_value
//  out_*       output     out_valid/out_stall ok, node_index, removed_value
//
//  The walk reads one node per cycle from the link store. After reset a
//  clearing pass builds the free chain; in_stall stays high for its length.
//  A two-entry command queue and the result register let requests be taken
//  while a result waits on out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_linked_list_engine_top #(
  parameter int unsigned NODE_COUNT = clle_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_list_head,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [7:0]         out_node_index,
  output logic signed [31:0] out_removed_value
);
  import clle_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic clearing;

  clle_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_list_head  (in_list_head),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  clle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd)
  );

  clle_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (pop_cmd),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_node_index    (out_node_index),
    .out_removed_value (out_removed_value)
  );

endmodule

`default_nettype wire

/* hw/rtl/clle_front.sv */
// ----------------------------------------------------------------------------
// clle_front
// Accepts requests, checks head and position, and pushes a classified
// command into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clle_front #(
  parameter int unsigned NODE_COUNT = clle_pkg::NODE_COUNT_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_list_head,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output clle_pkg::cmd_t     q_cmd
);
  import clle_pkg::*;

  logic head_ok;
  logic pos_ok;

  always_comb begin
    head_ok    = (in_list_head != 8'd0) && (32'(in_list_head) < NODE_COUNT);
    pos_ok     = (in_position != 8'd0);
    q_cmd.head = in_list_head;
    q_cmd.rem  = in_position - 8'd1;
    q_cmd.val  = in_item_value;
    case (in_req_type)
      REQ_CREATE: q_cmd.op = OP_CREATE;
      REQ_INSERT: q_cmd.op = (head_ok && pos_ok) ? OP_INSERT : OP_REJECT;
      REQ_DELETE: q_cmd.op = (head_ok && pos_ok) ? OP_DELETE : OP_REJECT;
      REQ_LOCATE: q_cmd.op = head_ok ? OP_LOCATE : OP_REJECT;
      default:    q_cmd.op = OP_REJECT;
    endcase
    in_stall = clearing || q_full;
    q_push   = in_valid && !in_stall;
  end

endmodule

`default_nettype wire

/* hw/rtl/clle_queue.sv */
// ----------------------------------------------------------------------------
// clle_queue
// Short command queue between the front end and the execution sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clle_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output clle_pkg::cmd_t pop_cmd
);
  import clle_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == CW'(QUEUE_DEPTH));
    valid      = (count_r != '0);
    pop_cmd    = slot_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/clle_back.sv */
// ----------------------------------------------------------------------------
// clle_back
// Execution sequencer: owns the link and value stores, walks lists one node
// per cycle, updates links one write per cycle and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clle_back #(
  parameter int unsigned NODE_COUNT = clle_pkg::NODE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  clle_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [7:0]         out_node_index,
  output logic signed [31:0] out_removed_value
);
  import clle_pkg::*;

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned SW = $clog2(NODE_COUNT + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(NODE_COUNT - 1);
  localparam logic [SW-1:0] STEP_MAX = SW'(NODE_COUNT);

  logic [IW-1:0] link_mem  [NODE_COUNT];
  logic [31:0]   value_mem [NODE_COUNT];
  logic [IW-1:0] link_rd_r;
  logic [31:0]   value_rd_r;

  state_t        state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] m_r, m_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic          from_mem_r, from_mem_nxt;
  logic          ins_r, ins_nxt;
  logic [31:0]   val_r, val_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [IW-1:0] res_idx_r, res_idx_nxt;
  logic [31:0]   res_val_r, res_val_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [7:0]    out_idx_r, out_idx_nxt;
  logic [31:0]   out_val_r, out_val_nxt;

  logic [IW-1:0] rd_addr;
  logic          lk_we;
  logic [IW-1:0] lk_wa;
  logic [IW-1:0] lk_wd;
  logic          vm_we;
  logic [IW-1:0] k_cur;
  logic [SW-1:0] step_inc;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    rem_nxt       = rem_r;
    steps_nxt     = steps_r;
    from_mem_nxt  = from_mem_r;
    ins_nxt       = ins_r;
    val_nxt       = val_r;
    res_ok_nxt    = res_ok_r;
    res_idx_nxt   = res_idx_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    rd_addr       = '0;
    lk_we         = 1'b0;
    lk_wa         = '0;
    lk_wd         = '0;
    vm_we         = 1'b0;
    q_pop         = 1'b0;
    k_cur         = '0;
    step_inc      = steps_r + 1'b1;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        lk_we = 1'b1;
        lk_wa = clr_r;
        lk_wd = (clr_r == IDX_LAST) ? '0 : clr_r + 1'b1;
        if (clr_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          res_ok_nxt   = 1'b0;
          res_idx_nxt  = '0;
          res_val_nxt  = '0;
          val_nxt      = q_cmd.val;
          rem_nxt      = q_cmd.rem;
          k_nxt        = IW'(q_cmd.head);
          from_mem_nxt = 1'b0;
          ins_nxt      = (q_cmd.op == OP_INSERT);
          case (q_cmd.op)
            OP_CREATE: begin
              rd_addr   = '0;
              state_nxt = ST_CR_HEAD;
            end
            OP_INSERT, OP_DELETE: begin
              state_nxt = ST_WALK;
            end
            OP_LOCATE: begin
              rd_addr   = IW'(q_cmd.head);
              steps_nxt = '0;
              state_nxt = ST_LOC_FIRST;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        k_cur = from_mem_r ? link_rd_r : k_r;
        if (k_cur == '0) begin
          state_nxt = ST_DONE;
        end else if (rem_r == 8'd0) begin
          k_nxt = k_cur;
          if (ins_r) begin
            rd_addr   = '0;
            state_nxt = ST_INS_HEAD;
          end else begin
            rd_addr   = k_cur;
            state_nxt = ST_DEL_GET;
          end
        end else begin
          rd_addr      = k_cur;
          k_nxt        = k_cur;
          rem_nxt      = rem_r - 8'd1;
          from_mem_nxt = 1'b1;
        end
      end
      ST_CR_HEAD: begin
        if (link_rd_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          m_nxt     = link_rd_r;
          rd_addr   = link_rd_r;
          state_nxt = ST_CR_POP;
        end
      end
      ST_CR_POP: begin
        lk_we     = 1'b1;
        lk_wa     = '0;
        lk_wd     = link_rd_r;
        state_nxt = ST_CR_END;
      end
      ST_CR_END: begin
        lk_we       = 1'b1;
        lk_wa       = m_r;
        lk_wd       = '0;
        res_ok_nxt  = 1'b1;
        res_idx_nxt = m_r;
        state_nxt   = ST_DONE;
      end
      ST_INS_HEAD: begin
        if (link_rd_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          m_nxt     = link_rd_r;
          rd_addr   = link_rd_r;
          state_nxt = ST_INS_POP;
        end
      end
      ST_INS_POP: begin
        lk_we     = 1'b1;
        lk_wa     = '0;
        lk_wd     = link_rd_r;
        rd_addr   = k_r;
        state_nxt = ST_INS_FILL;
      end
      ST_INS_FILL: begin
        lk_we     = 1'b1;
        lk_wa     = m_r;
        lk_wd     = link_rd_r;
        vm_we     = 1'b1;
        state_nxt = ST_INS_HOOK;
      end
      ST_INS_HOOK: begin
        lk_we      = 1'b1;
        lk_wa      = k_r;
        lk_wd      = m_r;
        res_ok_nxt = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DEL_GET: begin
        if (link_rd_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          m_nxt     = link_rd_r;
          rd_addr   = link_rd_r;
          state_nxt = ST_DEL_UNLINK;
        end
      end
      ST_DEL_UNLINK: begin
        lk_we     = 1'b1;
        lk_wa     = k_r;
        lk_wd     = link_rd_r;
        rd_addr   = m_r;
        state_nxt = ST_DEL_VAL;
      end
      ST_DEL_VAL: begin
        res_val_nxt = value_rd_r;
        rd_addr     = '0;
        state_nxt   = ST_DEL_FREE;
      end
      ST_DEL_FREE: begin
        lk_we     = 1'b1;
        lk_wa     = m_r;
        lk_wd     = link_rd_r;
        state_nxt = ST_DEL_END;
      end
      ST_DEL_END: begin
        lk_we      = 1'b1;
        lk_wa      = '0;
        lk_wd      = m_r;
        res_ok_nxt = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_LOC_FIRST: begin
        if (link_rd_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = link_rd_r;
          rd_addr   = link_rd_r;
          state_nxt = ST_LOC;
        end
      end
      ST_LOC: begin
        if (value_rd_r == val_r) begin
          res_ok_nxt  = 1'b1;
          res_idx_nxt = k_r;
          state_nxt   = ST_DONE;
        end else if ((link_rd_r == '0) || (step_inc == STEP_MAX)) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = link_rd_r;
          steps_nxt = step_inc;
          rd_addr   = link_rd_r;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_idx_nxt   = 8'(res_idx_r);
          out_val_nxt   = res_val_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    m_r        <= m_nxt;
    rem_r      <= rem_nxt;
    steps_r    <= steps_nxt;
    from_mem_r <= from_mem_nxt;
    ins_r      <= ins_nxt;
    val_r      <= val_nxt;
    res_ok_r   <= res_ok_nxt;
    res_idx_r  <= res_idx_nxt;
    res_val_r  <= res_val_nxt;
    out_ok_r   <= out_ok_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    link_rd_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      value_mem[m_r] <= val_r;
    end
    value_rd_r <= value_mem[rd_addr];
  end

  always_comb begin
    clearing          = (state_r == ST_CLEAR);
    out_valid         = out_valid_r;
    out_ok            = out_ok_r;
    out_node_index    = out_idx_r;
    out_removed_value = out_val_r;
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !q_pop)
    else $error("command taken during clearing pass");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_ok_r) |-> (res_idx_r == '0 && res_val_r == '0))
    else $error("failed request carries nonzero result fields");

  a_loc_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOC) |-> (k_r != '0))
    else $error("locate visits node zero");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result register loaded outside completion");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor linked-list engine. A directed table of
// requests comes first: empty lists, extreme values and positions, rejected
// heads, delete past the end, a self-linked node that sends locate on a
// runaway walk. Random create, insert, delete and locate requests follow, in
// phases that fill the store and drain it again. Results of typed rows are
// checked against their table, all others against a bench model of the store.
// ----------------------------------------------------------------------------

module tb;
  import clle_pkg::*;

  localparam int unsigned NODES       = NODE_COUNT_DEF;
  localparam int unsigned RANDOM_REQS = 1280;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned CALM_FROM   = 700;
  localparam int unsigned CALM_TO     = 900;

  typedef struct packed {
    logic        ok;
    logic [7:0]  idx;
    logic [31:0] removed;
  } result_t;

  typedef struct {
    logic [1:0]  rq;
    logic [7:0]  hd;
    logic [7:0]  pos;
    logic [31:0] v;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type   = REQ_CREATE;
  logic [7:0]         in_list_head  = 8'd0;
  logic [7:0]         in_position   = 8'd0;
  logic signed [31:0] in_item_value = 32'sd0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               out_ok;
  logic [7:0]         out_node_index;
  logic signed [31:0] out_removed_value;

  cursor_linked_list_engine_top #(
    .NODE_COUNT(NODES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_list_head     (in_list_head),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_node_index   (out_node_index),
    .out_removed_value(out_removed_value)
  );

  logic [31:0]  node_val [NODES];
  logic [7:0]   node_link[NODES];
  bit           val_written[NODES];
  int unsigned  list_heads[$];
  result_t      expected_results[$];
  dir_row_t     dir_rows[$];
  int unsigned  requests_taken = 0;
  int unsigned  errors = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned take_node();
    int unsigned m;
    m = 32'(node_link[0]);
    if (m != 0) node_link[0] = node_link[m];
    return m;
  endfunction

  function automatic int unsigned walk_pos(int unsigned hd, int unsigned pos);
    int unsigned k;
    int unsigned j;
    k = hd;
    j = 0;
    while (k != 0 && j + 1 < pos) begin
      j++;
      k = 32'(node_link[k]);
    end
    return k;
  endfunction

  function automatic int unsigned count_nodes(int unsigned hd);
    int unsigned k;
    int unsigned n;
    k = 32'(node_link[hd]);
    n = 0;
    while (k != 0 && n < NODES) begin
      n++;
      k = 32'(node_link[k]);
    end
    return n;
  endfunction

  function automatic result_t apply_request(logic [1:0] rq, logic [7:0] hd,
                                            logic [7:0] pos, logic [31:0] v);
    result_t     r;
    int unsigned k;
    int unsigned m;
    int unsigned steps;
    bit          head_ok;
    r = '0;
    head_ok = (hd != 0) && (hd < NODES);
    case (rq)
      REQ_CREATE: begin
        m = take_node();
        if (m != 0) begin
          node_link[m] = 8'd0;
          r.ok = 1'b1;
          r.idx = 8'(m);
          list_heads.push_back(m);
        end
      end
      REQ_INSERT: begin
        if (head_ok && pos >= 1) begin
          k = walk_pos(32'(hd), 32'(pos));
          if (k != 0) begin
            m = take_node();
            if (m != 0) begin
              node_val[m] = v;
              val_written[m] = 1'b1;
              node_link[m] = node_link[k];
              node_link[k] = 8'(m);
              r.ok = 1'b1;
            end
          end
        end
      end
      REQ_DELETE: begin
        if (head_ok && pos >= 1) begin
          k = walk_pos(32'(hd), 32'(pos));
          if (k != 0) begin
            m = 32'(node_link[k]);
            if (m != 0) begin
              node_link[k] = node_link[m];
              r.removed = node_val[m];
              node_link[m] = node_link[0];
              node_link[0] = 8'(m);
              r.ok = 1'b1;
            end
          end
        end
      end
      default: begin
        if (head_ok) begin
          k = 32'(node_link[hd]);
          steps = 0;
          while (k != 0 && node_val[k] != v && steps < NODES) begin
            k = 32'(node_link[k]);
            steps++;
          end
          if (k != 0 && steps < NODES) begin
            r.ok = 1'b1;
            r.idx = 8'(k);
          end
        end
      end
    endcase
    return r;
  endfunction

  // a request that would read a node value never written is sent as an insert instead
  function automatic bit touches_unwritten(logic [1:0] rq, logic [7:0] hd,
                                           logic [7:0] pos, logic [31:0] v);
    int unsigned k;
    int unsigned steps;
    if (hd == 0) return 1'b0;
    if (rq == REQ_DELETE && pos != 0) begin
      k = walk_pos(32'(hd), 32'(pos));
      return k != 0 && node_link[k] != 0 && !val_written[node_link[k]];
    end
    if (rq == REQ_LOCATE) begin
      k = 32'(node_link[hd]);
      steps = 0;
      while (k != 0) begin
        if (!val_written[k]) return 1'b1;
        if (node_val[k] == v || steps >= NODES) return 1'b0;
        k = 32'(node_link[k]);
        steps++;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit sender_gap();
    if (requests_taken >= CALM_FROM && requests_taken < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 30;
  endfunction

  task automatic add_row(input logic [1:0] rq, input logic [7:0] hd, input logic [7:0] pos,
                         input logic [31:0] v, input bit typed, input logic ok,
                         input logic [7:0] idx, input logic [31:0] rem);
    dir_row_t d;
    d.rq = rq;
    d.hd = hd;
    d.pos = pos;
    d.v = v;
    d.typed = typed;
    d.want = {ok, idx, rem};
    dir_rows.push_back(d);
  endtask

  task automatic offer_request(input logic [1:0] rq, input logic [7:0] hd,
                               input logic [7:0] pos, input logic [31:0] v,
                               input bit typed, input result_t fixed);
    result_t r;
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq;
    in_list_head  <= hd;
    in_position   <= pos;
    in_item_value <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = apply_request(rq, hd, pos, v);
    expected_results.push_back(typed ? fixed : r);
    requests_taken++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned k;
    int unsigned len;
    int unsigned p;
    int unsigned phase;
    int unsigned roll;
    int unsigned cw;
    int unsigned iw;
    int unsigned dw;
    logic [1:0]  rq;
    logic [7:0]  hd;
    logic [31:0] v;

    for (k = 0; k < NODES; k++) begin
      node_val[k] = '0;
      val_written[k] = 1'b0;
      node_link[k] = (k + 1 < NODES) ? 8'(k + 1) : 8'd0;
    end

    add_row(REQ_CREATE, 8'd0,   8'd0,   32'h0,        1'b1, 1'b1, 8'd1, 32'h0);
    add_row(REQ_LOCATE, 8'd1,   8'd0,   32'h5,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_DELETE, 8'd1,   8'd1,   32'h0,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd1,   8'd0,   32'h1,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd0,   8'd1,   32'h1,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_DELETE, 8'd0,   8'd1,   32'h0,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_LOCATE, 8'd0,   8'd0,   32'h0,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd1,   8'd1,   32'h7FFFFFFF, 1'b1, 1'b1, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd1,   8'd2,   32'h80000000, 1'b1, 1'b1, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd1,   8'd1,   32'h0,        1'b1, 1'b1, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd1,   8'd5,   32'h2,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd1,   8'd255, 32'hFFFFFFFF, 1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_LOCATE, 8'd1,   8'd0,   32'h80000000, 1'b1, 1'b1, 8'd3, 32'h0);
    add_row(REQ_LOCATE, 8'd1,   8'd255, 32'hFFFFFFFF, 1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_DELETE, 8'd1,   8'd4,   32'h0,        1'b1, 1'b0, 8'd0, 32'h0);
    add_row(REQ_DELETE, 8'd1,   8'd3,   32'h0,        1'b1, 1'b1, 8'd0, 32'h80000000);
    add_row(REQ_CREATE, 8'd0,   8'd0,   32'h0,        1'b1, 1'b1, 8'd3, 32'h0);
    add_row(REQ_INSERT, 8'd3,   8'd1,   32'h12345678, 1'b1, 1'b1, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd2,   8'd1,   32'h0F0F0F0F, 1'b0, 1'b0, 8'd0, 32'h0);
    add_row(REQ_LOCATE, 8'd2,   8'd0,   32'h0F0F0F0F, 1'b0, 1'b0, 8'd0, 32'h0);
    // insert at the first free node links it to itself
    add_row(REQ_INSERT, 8'd7,   8'd1,   32'h55AA55AA, 1'b0, 1'b0, 8'd0, 32'h0);
    add_row(REQ_LOCATE, 8'd7,   8'd0,   32'h00000001, 1'b0, 1'b0, 8'd0, 32'h0);
    add_row(REQ_LOCATE, 8'd7,   8'd0,   32'h55AA55AA, 1'b0, 1'b0, 8'd0, 32'h0);
    add_row(REQ_DELETE, 8'd7,   8'd1,   32'h0,        1'b0, 1'b0, 8'd0, 32'h0);
    add_row(REQ_DELETE, 8'd1,   8'd1,   32'h0,        1'b0, 1'b0, 8'd0, 32'h0);
    add_row(REQ_INSERT, 8'd255, 8'd1,   32'hA5A5A5A5, 1'b0, 1'b0, 8'd0, 32'h0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      offer_request(dir_rows[i].rq, dir_rows[i].hd, dir_rows[i].pos, dir_rows[i].v,
                    dir_rows[i].typed, dir_rows[i].want);

    for (n = 0; n < RANDOM_REQS; n++) begin
      phase = n * 4 / RANDOM_REQS;
      case (phase)
        1:       begin iw = 75; dw = 10; end
        2:       begin iw = 15; dw = 70; end
        default: begin iw = 40; dw = 30; end
      endcase
      cw = (list_heads.size() < 2) ? 30 : 5;
      roll = $urandom_range(0, 99);
      if (roll < cw) rq = REQ_CREATE;
      else if (roll < cw + iw) rq = REQ_INSERT;
      else if (roll < cw + iw + dw) rq = REQ_DELETE;
      else rq = REQ_LOCATE;

      roll = $urandom_range(0, 99);
      if (roll < 3) hd = 8'd0;
      else if (roll < 8 || list_heads.size() == 0) hd = 8'($urandom_range(1, 255));
      else hd = 8'(list_heads[$urandom_range(0, list_heads.size() - 1)]);
      len = (hd != 0) ? count_nodes(32'(hd)) : 0;

      roll = $urandom_range(0, 99);
      if (roll < 5) p = 0;
      else if (roll < 12) p = $urandom_range(0, 255);
      else if (roll < 20) p = (rq == REQ_INSERT) ? len + 2 : len + 1;
      else p = $urandom_range(1, (rq == REQ_INSERT) ? len + 1 : ((len > 0) ? len : 1));
      if (p > 255) p = 255;

      roll = $urandom_range(0, 99);
      v = $urandom;
      if (rq == REQ_LOCATE && len > 0 && roll < 60) begin
        k = walk_pos(32'(hd), $urandom_range(1, len) + 1);
        if (k != 0 && val_written[k]) v = node_val[k];
      end else if (roll < 20) begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0;
          1:       v = 32'h1;
          2:       v = 32'hFFFFFFFF;
          3:       v = 32'h80000000;
          4:       v = 32'h7FFFFFFF;
          default: v = $urandom_range(0, 7);
        endcase
      end

      if (touches_unwritten(rq, hd, 8'(p), v)) rq = REQ_INSERT;
      offer_request(rq, hd, 8'(p), v, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && requests_taken >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (requests_taken >= CALM_FROM && requests_taken < CALM_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: ok %0d index %0d removed %h",
                   out_ok, out_node_index, out_removed_value);
      end else begin
        want = expected_results.pop_front();
        if (out_ok !== want.ok || out_node_index !== want.idx ||
            out_removed_value !== want.removed) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: ok %0d/%0d index %0d/%0d removed %h/%h (expected/actual)",
                     want.ok, out_ok, want.idx, out_node_index,
                     want.removed, out_removed_value);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
